FILE: design/set_assoc_cache_tag_lru_core_defines.svh
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_core_defines
// assertion macros shared by the tag store design
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LRU_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LRU_CORE_DEFINES_SVH

// same-cycle implication
`define SACTL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sactl check failed");

// next-cycle implication
`define SACTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sactl check failed");

`endif

FILE: design/sactl_pkg.sv
// ----------------------------------------------------------------------------
// sactl_pkg
// constants, types and the lfsr step of the set associative tag store
// ----------------------------------------------------------------------------
package sactl_pkg;

  localparam int NUM_BLOCKS_DEF = 64;
  localparam int AGE_WIDTH_DEF  = 16;
  localparam int STAMP_W        = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRITE_POLICY = 2'd0,
    REG_WAYS_LOG2    = 2'd1,
    REG_OFFSET_BITS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ 16'hB400;
    end
    return s;
  endfunction

endpackage

FILE: design/set_assoc_cache_tag_lru_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_core
// tag store of one cache level with lru or random replacement
// ----------------------------------------------------------------------------
// usage:
//   input channel carries a byte address and a write flag; the result channel
//   returns hit, slot, write_back and the running hit and miss totals, one
//   result per access. the cfg port sets write policy, associativity and
//   offset bits; write it only while the block is idle, which the block
//   itself does not enforce. per access: accept, then the set index
//   remainder (skipped when the set count is a power of two, else through
//   a bit-serial remainder unit; in fully associative mode the random
//   value is reduced the same way), then one tag memory read per way and
//   a drain of the read pipeline, then the write-back. the tag memory has
//   a single read port, and the block takes no new access until it has
//   finished the last one. ages are kept as access time stamps, so aging
//   all blocks costs nothing. reset clears valid bits and counters, seeds
//   the random generator and sets the config to its defaults; no clearing
//   pass is needed. a stalled result is held in the output register while
//   the next access is already accepted and looked up.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_core
  import sactl_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int AGE_WIDTH  = AGE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_byte_address,
  input  logic                  in_is_write,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [5:0]            out_slot,
  output logic                  out_write_back,
  output logic [31:0]           out_hit_total,
  output logic [31:0]           out_miss_total
);

  `include "set_assoc_cache_tag_lru_core_defines.svh"

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int RW = IW + 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam logic [RW-1:0] NB_R = RW'(NUM_BLOCKS);
  localparam logic [CW-1:0] NB_C = CW'(NUM_BLOCKS);
  localparam logic [AGE_WIDTH-1:0] AMAX = {AGE_WIDTH{1'b1}};

  typedef struct packed {
    logic [31:0]        tag;
    logic               dirty;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  entry_t mem [NUM_BLOCKS];
  entry_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  logic              wpol_r;
  logic [2:0]        wl_r;
  logic [3:0]        off_r;
  state_t            state_r;
  logic [STAMP_W-1:0] now_r;
  logic [NUM_BLOCKS-1:0] valid_r;
  logic [15:0]       lfsr_r, lfsr_cand_r;
  logic [31:0]       hits_r, misses_r;

  logic [31:0]       blk_r;
  logic              wr_r, full_r;
  logic [CW-1:0]     ways_r;
  logic [31:0]       dvd_r;
  logic [RW-1:0]     dvsr_r, rem_r;
  logic [5:0]        dcnt_r;

  logic [CW-1:0]     iss_r;
  logic              pv_r, pfirst_r;
  logic [IW-1:0]     pslot_r;
  logic              hit_r, hit_dirty_r;
  logic [IW-1:0]     hit_slot_r, best_slot_r;
  logic [AGE_WIDTH-1:0] best_age_r;
  logic              best_wb_r, rand_wb_r;

  logic              ov_r, o_hit_r, o_wb_r;
  logic [5:0]        o_slot_r;
  logic [31:0]       o_hits_r, o_misses_r;

  // accept-time decode
  logic              in_xfer;
  logic [31:0]       blk_c, dvd_c;
  logic              full_c, pow2_c;
  logic [7:0]        ways_raw;
  logic [RW-1:0]     sets_c, dvsr_c, rem_c;
  logic [15:0]       lfsr_c;

  always_comb begin
    in_xfer  = in_valid && !in_stall;
    blk_c    = in_byte_address >> off_r;
    ways_raw = 8'd1 << wl_r;
    full_c   = 32'(ways_raw) >= 32'(NUM_BLOCKS);
    sets_c   = NB_R >> wl_r;
    lfsr_c   = lfsr_next(lfsr_r);
    dvsr_c   = full_c ? NB_R : sets_c;
    dvd_c    = full_c ? {16'h0, lfsr_c} : blk_c;
    pow2_c   = (dvsr_c & (dvsr_c - RW'(1))) == '0;
    rem_c    = {1'b0, dvd_c[IW-1:0] & dvsr_c[IW-1:0] - IW'(1)};
  end

  // divider step
  logic [RW-1:0] dtry;
  always_comb begin
    dtry = {rem_r[RW-2:0], dvd_r[31]};
  end

  // scan addressing
  logic [IW-1:0] base_c;
  logic          issuing;
  always_comb begin
    base_c  = full_r ? '0 : IW'(rem_r[IW-1:0] << wl_r);
    issuing = (state_r == ST_SCAN) && (iss_r < ways_r);
    rd_addr = base_c + iss_r[IW-1:0];
  end

  // age of the entry being processed
  logic               pval;
  logic [STAMP_W-1:0] pdiff;
  logic [AGE_WIDTH-1:0] page;
  logic               phit;
  always_comb begin
    pval  = valid_r[pslot_r];
    pdiff = now_r - (pval ? rd_q.stamp : '0);
    page  = (pdiff > STAMP_W'(AMAX)) ? AMAX : pdiff[AGE_WIDTH-1:0];
    phit  = pval && (rd_q.tag == blk_r);
  end

  // finish
  logic          fin_go, dirty_new;
  logic [IW-1:0] vslot;
  logic          vwb;
  logic [IW+5:0] slot_ext;
  always_comb begin
    fin_go    = (state_r == ST_FIN) && !(ov_r && out_stall);
    dirty_new = wr_r && !wpol_r;
    vslot     = hit_r ? hit_slot_r : (full_r ? rem_r[IW-1:0] : best_slot_r);
    vwb       = hit_r ? 1'b0 : (full_r ? rand_wb_r : best_wb_r);
    slot_ext  = {6'b0, vslot};
    wr_en     = fin_go;
    wr_addr   = vslot;
    wr_data.tag   = blk_r;
    wr_data.dirty = hit_r ? (hit_dirty_r | dirty_new) : dirty_new;
    wr_data.stamp = now_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpol_r <= 1'b0;
      wl_r   <= 3'd2;
      off_r  <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WRITE_POLICY: wpol_r <= cfg_data[0];
        REG_WAYS_LOG2:    wl_r   <= cfg_data[2:0];
        REG_OFFSET_BITS:  off_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      valid_r  <= '0;
      lfsr_r   <= 16'h0001;
      hits_r   <= '0;
      misses_r <= '0;
      pv_r     <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (fin_go) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            now_r  <= now_r + STAMP_W'(1);
            state_r <= pow2_c ? ST_SCAN : ST_DIV;
          end
        end
        ST_DIV: begin
          if (dcnt_r == 6'd31) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pv_r <= issuing;
          if (!issuing && !pv_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            valid_r[vslot] <= 1'b1;
            state_r <= ST_IDLE;
            if (hit_r) begin
              hits_r <= (hits_r == '1) ? hits_r : hits_r + 32'd1;
            end else begin
              misses_r <= (misses_r == '1) ? misses_r : misses_r + 32'd1;
              if (full_r) begin
                lfsr_r <= lfsr_cand_r;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      blk_r       <= blk_c;
      wr_r        <= in_is_write;
      full_r      <= full_c;
      ways_r      <= full_c ? NB_C : CW'(ways_raw);
      dvd_r       <= dvd_c;
      dvsr_r      <= dvsr_c;
      rem_r       <= pow2_c ? rem_c : '0;
      dcnt_r      <= '0;
      lfsr_cand_r <= lfsr_c;
      iss_r       <= '0;
      hit_r       <= 1'b0;
    end
    if (state_r == ST_DIV) begin
      rem_r  <= (dtry >= dvsr_r) ? dtry - dvsr_r : dtry;
      dvd_r  <= {dvd_r[30:0], 1'b0};
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (issuing) begin
      iss_r    <= iss_r + CW'(1);
      pslot_r  <= rd_addr;
      pfirst_r <= (iss_r == '0);
    end
    if ((state_r == ST_SCAN) && pv_r) begin
      if (phit && !hit_r) begin
        hit_r       <= 1'b1;
        hit_slot_r  <= pslot_r;
        hit_dirty_r <= rd_q.dirty;
      end
      if (pfirst_r || (page > best_age_r)) begin
        best_age_r  <= page;
        best_slot_r <= pslot_r;
        best_wb_r   <= pval && rd_q.dirty;
      end
      if (pslot_r == rem_r[IW-1:0]) begin
        rand_wb_r <= pval && rd_q.dirty;
      end
    end
    if (fin_go) begin
      o_hit_r    <= hit_r;
      o_slot_r   <= slot_ext[5:0];
      o_wb_r     <= vwb;
      o_hits_r   <= (hit_r && (hits_r != '1)) ? hits_r + 32'd1 : hits_r;
      o_misses_r <= (!hit_r && (misses_r != '1)) ? misses_r + 32'd1 : misses_r;
    end
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = ov_r;
  assign out_hit        = o_hit_r;
  assign out_slot       = o_slot_r;
  assign out_write_back = o_wb_r;
  assign out_hit_total  = o_hits_r;
  assign out_miss_total = o_misses_r;

  `SACTL_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall)
  `SACTL_ASSERT_NEXT(a_fin_loads_out, fin_go, ov_r && (state_r == ST_IDLE))
  `SACTL_ASSERT_NOW(a_scan_bound, state_r == ST_SCAN, iss_r <= ways_r)
  `SACTL_ASSERT_NOW(a_no_wb_on_hit, ov_r && o_hit_r, !o_wb_r)

endmodule

FILE: bench/set_assoc_cache_tag_lru_core_tb.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_core_tb
// self-checking bench for the cache tag store: a directed table of accesses,
// then random access streams over several policy, associativity and offset
// settings; every result is checked against table values or a behavioral
// lru tag store model, under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_core_tb
  import sactl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 64;
  localparam int LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic        hit;
    logic [5:0]  slot;
    logic        wb;
    logic [31:0] hits;
    logic [31:0] misses;
  } access_result_t;

  typedef struct {
    logic [31:0]    addr;
    logic           wr;
    logic           known;
    access_result_t res;
  } access_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_byte_address = '0;
  logic in_is_write = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [5:0] out_slot;
  logic out_write_back;
  logic [31:0] out_hit_total;
  logic [31:0] out_miss_total;

  set_assoc_cache_tag_lru_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tag store shadow
  logic [31:0] tag_q [NBLK];
  logic        valid_q [NBLK];
  logic        dirty_q [NBLK];
  logic [15:0] age_q [NBLK];
  logic [15:0] lfsr_q = 16'd1;
  logic [31:0] hit_cnt_q = '0;
  logic [31:0] miss_cnt_q = '0;
  logic        policy_q = 1'b0;
  logic [2:0]  ways_log2_q = 3'd2;
  logic [3:0]  offset_q = 4'd4;

  access_result_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cnt = 0;
  logic [31:0] addr_pool [32];

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      tag_q[i] = '0;
      valid_q[i] = 1'b0;
      dirty_q[i] = 1'b0;
      age_q[i] = '0;
    end
  end

  function automatic access_result_t access_tags(logic [31:0] addr, logic wr);
    logic [31:0] blk;
    int ways, sets, base, s;
    logic full;
    logic [15:0] best;
    access_result_t r;
    blk = addr >> offset_q;
    ways = 1 << ways_log2_q;
    full = (ways >= NBLK);
    if (full) ways = NBLK;
    sets = NBLK / ways;
    base = int'(blk % sets) * ways;
    r.hit = 1'b0;
    r.wb = 1'b0;
    s = 0;
    for (int i = 0; i < NBLK; i++)
      if (age_q[i] != 16'hFFFF) age_q[i] = age_q[i] + 1'b1;
    for (int i = 0; i < ways; i++) begin
      if (!r.hit && valid_q[base + i] && tag_q[base + i] == blk) begin
        r.hit = 1'b1;
        s = base + i;
      end
    end
    if (r.hit) begin
      if (hit_cnt_q != 32'hFFFF_FFFF) hit_cnt_q = hit_cnt_q + 1;
      age_q[s] = '0;
      if (wr && !policy_q) dirty_q[s] = 1'b1;
    end else begin
      if (miss_cnt_q != 32'hFFFF_FFFF) miss_cnt_q = miss_cnt_q + 1;
      if (full) begin
        lfsr_q = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? 16'hB400 : 16'h0000);
        s = lfsr_q % NBLK;
      end else begin
        s = base;
        best = age_q[base];
        for (int i = 1; i < ways; i++) begin
          if (age_q[base + i] > best) begin
            best = age_q[base + i];
            s = base + i;
          end
        end
      end
      r.wb = valid_q[s] && dirty_q[s];
      tag_q[s] = blk;
      valid_q[s] = 1'b1;
      age_q[s] = '0;
      dirty_q[s] = wr && !policy_q;
    end
    r.slot = s[5:0];
    r.hits = hit_cnt_q;
    r.misses = miss_cnt_q;
    return r;
  endfunction

  task automatic send_access(logic [31:0] addr, logic wr, logic known, access_result_t typed);
    access_result_t r;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_address <= addr;
    in_is_write <= wr;
    do @(posedge clk); while (in_stall);
    r = access_tags(addr, wr);
    pending_q.push_back(known ? typed : r);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic pol, logic [2:0] wl2, logic [3:0] off);
    cfg_we <= 1'b1;
    cfg_index <= REG_WRITE_POLICY;
    cfg_data <= {3'b000, pol};
    @(posedge clk);
    cfg_index <= REG_WAYS_LOG2;
    cfg_data <= {1'b0, wl2};
    @(posedge clk);
    cfg_index <= REG_OFFSET_BITS;
    cfg_data <= off;
    @(posedge clk);
    cfg_we <= 1'b0;
    policy_q = pol;
    ways_log2_q = wl2;
    offset_q = off;
  endtask

  task automatic random_stream(int count);
    logic [31:0] a;
    logic [31:0] mask;
    access_result_t none;
    none = '{default: '0};
    mask = (32'd1 << offset_q) - 1;
    for (int i = 0; i < 32; i++) addr_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85)
        a = addr_pool[$urandom_range(0, 31)] ^ ($urandom & mask);
      else
        a = $urandom;
      send_access(a, 1'($urandom_range(0, 1)), 1'b0, none);
    end
  endtask

  // sink stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    access_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0d actual %0d", e.hit, out_hit);
          errors++;
        end
        if (out_slot !== e.slot) begin
          $error("slot: expected %0d actual %0d", e.slot, out_slot);
          errors++;
        end
        if (out_write_back !== e.wb) begin
          $error("write_back: expected %0d actual %0d", e.wb, out_write_back);
          errors++;
        end
        if (out_hit_total !== e.hits) begin
          $error("hit_total: expected %0d actual %0d", e.hits, out_hit_total);
          errors++;
        end
        if (out_miss_total !== e.misses) begin
          $error("miss_total: expected %0d actual %0d", e.misses, out_miss_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  access_row_t directed [13];

  initial begin
    directed[0]  = '{32'h0000_0000, 1'b0, 1'b1, '{1'b0, 6'd0, 1'b0, 32'd0, 32'd1}};
    directed[1]  = '{32'h0000_000F, 1'b1, 1'b1, '{1'b1, 6'd0, 1'b0, 32'd1, 32'd1}};
    directed[2]  = '{32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 6'd60, 1'b0, 32'd1, 32'd2}};
    directed[3]  = '{32'h0000_0100, 1'b0, 1'b0, '{default: '0}};
    directed[4]  = '{32'h0000_0200, 1'b1, 1'b0, '{default: '0}};
    directed[5]  = '{32'h0000_0300, 1'b0, 1'b0, '{default: '0}};
    directed[6]  = '{32'h0000_0400, 1'b0, 1'b0, '{default: '0}};
    directed[7]  = '{32'h0000_0000, 1'b0, 1'b0, '{default: '0}};
    directed[8]  = '{32'hFFFF_FFF0, 1'b0, 1'b0, '{default: '0}};
    directed[9]  = '{32'h8000_0000, 1'b1, 1'b0, '{default: '0}};
    directed[10] = '{32'h7FFF_FFFF, 1'b0, 1'b0, '{default: '0}};
    directed[11] = '{32'h5555_5555, 1'b1, 1'b0, '{default: '0}};
    directed[12] = '{32'hAAAA_AAAA, 1'b0, 1'b0, '{default: '0}};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_access(directed[i].addr, directed[i].wr, directed[i].known, directed[i].res);
    random_stream(200);
    drain_and_settle();

    write_cfg(1'b0, 3'd0, 4'd0);
    gap_pct = 77; stall_pct = 0;
    random_stream(130);
    drain_and_settle();

    write_cfg(1'b1, 3'd6, 4'd12);
    gap_pct = 0; stall_pct = 77;
    random_stream(110);
    drain_and_settle();

    write_cfg(1'b0, 3'd6, 4'd0);
    gap_pct = 15; stall_pct = 15;
    random_stream(110);
    drain_and_settle();

    write_cfg(1'b1, 3'd3, 4'd7);
    gap_pct = 0; stall_pct = 0;
    hold_tog <= ~hold_tog;
    random_stream(140);
    drain_and_settle();

    write_cfg(1'b0, 3'd5, 4'd12);
    gap_pct = 77; stall_pct = 0;
    random_stream(120);
    drain_and_settle();

    write_cfg(1'b0, 3'd1, 4'd2);
    gap_pct = 0; stall_pct = 77;
    random_stream(130);
    drain_and_settle();

    write_cfg(1'b1, 3'd4, 4'd4);
    gap_pct = 15; stall_pct = 15;
    random_stream(130);
    drain_and_settle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
